// ----- hdl/heightmap_triangle_sample_core_assert.svh -----
// Assertion macros for the heightmap sampler checker.
`ifndef HEIGHTMAP_TRIANGLE_SAMPLE_CORE_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLE_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent, outside reset.
`define HTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent, outside reset.
`define HTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after reset is applied.
`define HTS_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/htsamp_pkg.sv -----
// Shared constants and types of the heightmap triangle sampler.
`default_nettype none

package htsamp_pkg;

    // Grid store limits
    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 256;

    // Column and row index widths, and the halves used inside one parity bank
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned CH_W       = (COL_W > 1) ? COL_W - 1 : 1;
    localparam int unsigned RH_W       = (ROW_W > 1) ? ROW_W - 1 : 1;
    localparam int unsigned BANK_AW    = CH_W + RH_W;
    localparam int unsigned BANK_DEPTH = 1 << BANK_AW;
    localparam int unsigned NUM_BANKS  = 4;

    // Field widths
    localparam int unsigned SIZE_W    = 9;
    localparam int unsigned SCALE_W   = 24;
    localparam int unsigned COORD_W   = 24;
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned HEIGHT_W  = 24;
    localparam int unsigned CFG_IDX_W = 3;

    // Result constants: -1.0 in Q16.8 and the saturation limit
    localparam logic [HEIGHT_W-1:0] HEIGHT_OUTSIDE = 24'hFFFF00;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX     = 24'h7FFFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH    = 3'd0,
        CFG_GRID_HEIGHT   = 3'd1,
        CFG_X_INV_SCALE   = 3'd2,
        CFG_Y_INV_SCALE   = 3'd3,
        CFG_H_INV_SCALE   = 3'd4
    } t_cfg_index;

endpackage

`default_nettype wire

// ----- hdl/heightmap_triangle_sample_core.sv -----
// Top level of the heightmap triangle sampler: grid store, query pipeline, output skid.
// Queries pass the stage registers and the output register; four parity banks serve all corners.
// Throughput: one request per cycle while o_in_ready is high, loads and queries mixed.
// Stalls: a two-entry output (register plus skid) lets one more result in before o_in_ready drops.
// Reset: clears valid bits, load counters and registers to their reset values; store keeps data.
`default_nettype none

module heightmap_triangle_sample_core import htsamp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [SAMPLE_W-1:0]        i_sample,
    input  logic signed [COORD_W-1:0]  i_x_coord,
    input  logic signed [COORD_W-1:0]  i_y_coord,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [HEIGHT_W-1:0] o_height,
    output logic                       o_outside,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [SCALE_W-1:0]         i_cfg_data
);

    // Configuration and load position
    logic [SIZE_W-1:0]  r_grid_width;
    logic [SIZE_W-1:0]  r_grid_height;
    logic [SCALE_W-1:0] r_x_inv_scale;
    logic [SCALE_W-1:0] r_y_inv_scale;
    logic [SCALE_W-1:0] r_h_inv_scale;
    logic [COL_W-1:0]   r_load_col;
    logic [ROW_W-1:0]   r_load_row;
    logic [COL_W-1:0]   n_load_col;
    logic [ROW_W-1:0]   n_load_row;

    logic               adv;
    logic               in_acc;
    logic               cfg_acc;
    logic [COL_W:0]     w_use;
    logic [ROW_W:0]     h_use;
    logic [COL_W:0]     w_load;
    logic [ROW_W:0]     h_load;
    logic [COL_W:0]     load_col_inc;
    logic [ROW_W:0]     load_row_inc;

    // Stage 1: accepted request
    logic                      r_s1_valid;
    logic                      r_s1_mode;
    logic [SAMPLE_W-1:0]       r_s1_sample;
    logic signed [COORD_W-1:0] r_s1_x;
    logic signed [COORD_W-1:0] r_s1_y;
    logic [COL_W-1:0]          r_s1_wcol;
    logic [ROW_W-1:0]          r_s1_wrow;

    // Stage 2: grid coordinates in Q.24
    logic                      r_s2_valid;
    logic                      r_s2_mode;
    logic [SAMPLE_W-1:0]       r_s2_sample;
    logic [COL_W-1:0]          r_s2_wcol;
    logic [ROW_W-1:0]          r_s2_wrow;
    logic [47:0]               r_s2_gx;
    logic [47:0]               r_s2_gy;
    logic signed [48:0]        gx_prod;
    logic signed [48:0]        gy_prod;
    logic signed [COORD_W:0]   neg_y;

    // Stage 2 to 3: bound check and bank access
    logic [COORD_W-1:0]        col_full;
    logic [COORD_W-1:0]        row_full;
    logic                      col_off;
    logic                      row_off;
    logic                      q_outside;
    logic [COL_W-1:0]          q_col;
    logic [ROW_W-1:0]          q_row;
    logic [COL_W:0]            q_col_inc;
    logic [ROW_W:0]            q_row_inc;
    logic [CH_W-1:0]           col_half [2];
    logic [RH_W-1:0]           row_half [2];
    logic [1:0]                wbank;
    logic [BANK_AW-1:0]        waddr;
    logic [SAMPLE_W-1:0]       bank_q [NUM_BANKS];

    // Stage 3: fractions, bank data arrives
    logic                      r_s3_valid;
    logic                      r_s3_outside;
    logic [23:0]               r_s3_pu;
    logic [23:0]               r_s3_pv;
    logic                      r_s3_c0;
    logic                      r_s3_r0;
    logic [SAMPLE_W-1:0]       p00;
    logic [SAMPLE_W-1:0]       p10;
    logic [SAMPLE_W-1:0]       p01;
    logic [SAMPLE_W-1:0]       p11;
    logic                      upper_tri;
    logic signed [SAMPLE_W:0]  da;
    logic signed [SAMPLE_W:0]  db;

    // Stage 4: triangle slopes
    logic                      r_s4_valid;
    logic                      r_s4_outside;
    logic [SAMPLE_W-1:0]       r_s4_p00;
    logic signed [SAMPLE_W:0]  r_s4_da;
    logic signed [SAMPLE_W:0]  r_s4_db;
    logic [23:0]               r_s4_pu;
    logic [23:0]               r_s4_pv;
    logic signed [33:0]        ma;
    logic signed [33:0]        mb;

    // Stage 5: slope products
    logic                      r_s5_valid;
    logic                      r_s5_outside;
    logic [SAMPLE_W-1:0]       r_s5_p00;
    logic signed [33:0]        r_s5_ma;
    logic signed [33:0]        r_s5_mb;
    logic signed [35:0]        hsum;

    // Stage 6: interpolated height, Q8.24
    logic                      r_s6_valid;
    logic                      r_s6_outside;
    logic [31:0]               r_s6_h;

    // Stage 7: scaled height, Q.40
    logic                      r_s7_valid;
    logic                      r_s7_outside;
    logic [55:0]               r_s7_acc;
    logic [56:0]               rnd;
    logic [24:0]               hq;
    logic [HEIGHT_W-1:0]       res_height;

    // Output register and skid
    logic                      r_out_valid;
    logic [HEIGHT_W-1:0]       r_out_height;
    logic                      r_out_outside;
    logic                      r_skid_valid;
    logic [HEIGHT_W-1:0]       r_skid_height;
    logic                      r_skid_outside;

    // Advance the whole pipeline while the skid is empty
    assign adv         = !r_skid_valid;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && adv;
    assign cfg_acc     = i_cfg_valid;

    // Clamp the grid size in use to the store limits
    always_comb begin
        w_use  = (32'(r_grid_width) > MAX_WIDTH) ? (COL_W+1)'(MAX_WIDTH)
                                                : (COL_W+1)'(r_grid_width);
        h_use  = (32'(r_grid_height) > MAX_HEIGHT) ? (ROW_W+1)'(MAX_HEIGHT)
                                                  : (ROW_W+1)'(r_grid_height);
        w_load = (w_use == '0) ? (COL_W+1)'(1) : w_use;
        h_load = (h_use == '0) ? (ROW_W+1)'(1) : h_use;
    end

    // Step the load position: rows inner, columns outer
    always_comb begin
        load_col_inc = {1'b0, r_load_col} + (COL_W+1)'(1);
        load_row_inc = {1'b0, r_load_row} + (ROW_W+1)'(1);
        n_load_col   = r_load_col;
        n_load_row   = r_load_row[ROW_W-1:0];
        if (load_row_inc >= h_load) begin
            n_load_row = '0;
            if (load_col_inc >= w_load) begin
                n_load_col = '0;
            end else begin
                n_load_col = load_col_inc[COL_W-1:0];
            end
        end else begin
            n_load_row = load_row_inc[ROW_W-1:0];
        end
    end

    // Hold configuration; restart loading on a resize
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= SIZE_W'(256);
            r_grid_height <= SIZE_W'(256);
            r_x_inv_scale <= SCALE_W'(65536);
            r_y_inv_scale <= SCALE_W'(65536);
            r_h_inv_scale <= SCALE_W'(65536);
            r_load_col    <= '0;
            r_load_row    <= '0;
        end else if (cfg_acc) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[SIZE_W-1:0];
                    r_load_col   <= '0;
                    r_load_row   <= '0;
                end
                CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[SIZE_W-1:0];
                    r_load_col    <= '0;
                    r_load_row    <= '0;
                end
                CFG_X_INV_SCALE: r_x_inv_scale <= i_cfg_data;
                CFG_Y_INV_SCALE: r_y_inv_scale <= i_cfg_data;
                CFG_H_INV_SCALE: r_h_inv_scale <= i_cfg_data;
                default: ;
            endcase
        end else if (in_acc && !i_mode) begin
            r_load_col <= n_load_col;
            r_load_row <= n_load_row;
        end
    end

    // Scale coordinates to grid units
    always_comb begin
        neg_y   = -$signed({r_s1_y[COORD_W-1], r_s1_y});
        gx_prod = $signed(r_s1_x) * $signed({1'b0, r_x_inv_scale});
        gy_prod = neg_y * $signed({1'b0, r_y_inv_scale});
    end

    // Locate the cell, check bounds, form bank addresses
    always_comb begin
        col_full  = r_s2_gx[47:24];
        row_full  = r_s2_gy[47:24];
        col_off   = ({1'b0, col_full} + 25'd1) >= 25'(w_use);
        row_off   = ({1'b0, row_full} + 25'd1) >= 25'(h_use);
        q_outside = r_s2_gx[47] || r_s2_gy[47] || col_off || row_off;
        q_col     = col_full[COL_W-1:0];
        q_row     = row_full[ROW_W-1:0];
        q_col_inc = {1'b0, q_col} + (COL_W+1)'(1);
        q_row_inc = {1'b0, q_row} + (ROW_W+1)'(1);
        for (int p = 0; p < 2; p++) begin
            col_half[p] = (q_col[0] == p[0]) ? CH_W'({1'b0, q_col} >> 1)
                                            : CH_W'(q_col_inc >> 1);
            row_half[p] = (q_row[0] == p[0]) ? RH_W'({1'b0, q_row} >> 1)
                                            : RH_W'(q_row_inc >> 1);
        end
        wbank = {r_s2_wrow[0], r_s2_wcol[0]};
        waddr = {RH_W'(r_s2_wrow >> 1), CH_W'(r_s2_wcol >> 1)};
    end

    // Parity banks: each corner of a cell lands in its own bank
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        htsamp_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (adv && r_s2_valid && !r_s2_mode && (wbank == 2'(b))),
            .i_waddr (waddr),
            .i_wdata (r_s2_sample),
            .i_re    (adv),
            .i_raddr ({row_half[b / 2], col_half[b % 2]}),
            .o_rdata (bank_q[b])
        );
    end

    // Pick the corners and the triangle slopes
    always_comb begin
        p00       = bank_q[{r_s3_r0, r_s3_c0}];
        p10       = bank_q[{r_s3_r0, !r_s3_c0}];
        p01       = bank_q[{!r_s3_r0, r_s3_c0}];
        p11       = bank_q[{!r_s3_r0, !r_s3_c0}];
        upper_tri = r_s3_pu > r_s3_pv;
        if (upper_tri) begin
            da = $signed({1'b0, p10}) - $signed({1'b0, p00});
            db = $signed({1'b0, p11}) - $signed({1'b0, p10});
        end else begin
            da = $signed({1'b0, p11}) - $signed({1'b0, p01});
            db = $signed({1'b0, p01}) - $signed({1'b0, p00});
        end
    end

    // Multiply slopes by fractions
    always_comb begin
        ma = r_s4_da * $signed({1'b0, r_s4_pu});
        mb = r_s4_db * $signed({1'b0, r_s4_pv});
    end

    // Sum base and slope terms
    assign hsum = $signed({4'b0, r_s5_p00, 24'b0}) + $signed({{2{r_s5_ma[33]}}, r_s5_ma})
                + $signed({{2{r_s5_mb[33]}}, r_s5_mb});

    // Round to Q16.8 and saturate; off-grid results get -1.0
    always_comb begin
        rnd = {1'b0, r_s7_acc} + 57'h0_8000_0000;
        hq  = rnd[56:32];
        if (r_s7_outside) begin
            res_height = HEIGHT_OUTSIDE;
        end else if (hq > {1'b0, HEIGHT_MAX}) begin
            res_height = HEIGHT_MAX;
        end else begin
            res_height = hq[HEIGHT_W-1:0];
        end
    end

    // Advance valid bits; loads drop out once written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_mode;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mode    <= i_mode;
            r_s1_sample  <= i_sample;
            r_s1_x       <= i_x_coord;
            r_s1_y       <= i_y_coord;
            r_s1_wcol    <= r_load_col;
            r_s1_wrow    <= r_load_row;

            r_s2_mode    <= r_s1_mode;
            r_s2_sample  <= r_s1_sample;
            r_s2_wcol    <= r_s1_wcol;
            r_s2_wrow    <= r_s1_wrow;
            r_s2_gx      <= gx_prod[47:0];
            r_s2_gy      <= gy_prod[47:0];

            r_s3_outside <= q_outside;
            r_s3_pu      <= r_s2_gx[23:0];
            r_s3_pv      <= r_s2_gy[23:0];
            r_s3_c0      <= q_col[0];
            r_s3_r0      <= q_row[0];

            r_s4_outside <= r_s3_outside;
            r_s4_p00     <= p00;
            r_s4_da      <= da;
            r_s4_db      <= db;
            r_s4_pu      <= r_s3_pu;
            r_s4_pv      <= r_s3_pv;

            r_s5_outside <= r_s4_outside;
            r_s5_p00     <= r_s4_p00;
            r_s5_ma      <= ma;
            r_s5_mb      <= mb;

            r_s6_outside <= r_s5_outside;
            r_s6_h       <= hsum[35] ? 32'd0 : hsum[31:0];

            r_s7_outside <= r_s6_outside;
            r_s7_acc     <= 56'(r_s6_h) * 56'(r_h_inv_scale);
        end
    end

    // Hand results out; park one in the skid when the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_out_ready) begin
            if (adv && r_s7_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_out_ready) begin
            if (adv && r_s7_valid) begin
                r_skid_height  <= res_height;
                r_skid_outside <= r_s7_outside;
            end
        end else if (r_skid_valid) begin
            r_out_height  <= r_skid_height;
            r_out_outside <= r_skid_outside;
        end else begin
            r_out_height  <= res_height;
            r_out_outside <= r_s7_outside;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_height    = $signed(r_out_height);
    assign o_outside   = r_out_outside;

endmodule

`default_nettype wire

// ----- hdl/htsamp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module htsamp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16384,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/htsamp_chk.sv -----
// Port-level checker for the heightmap sampler, bound to the top level.
`default_nettype none

`include "heightmap_triangle_sample_core_assert.svh"

module htsamp_chk import htsamp_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [HEIGHT_W-1:0] o_height,
    input logic                       o_outside
);

    // A stalled result holds
    `HTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_height) && $stable(o_outside), "stalled result changed")

    // An off-grid result carries -1.0
    `HTS_ASSERT_NOW(a_outside_value, i_clk, i_rst_n, o_out_valid && o_outside, o_height == $signed(HEIGHT_OUTSIDE), "off-grid result without -1.0")

    // An on-grid height is never negative
    `HTS_ASSERT_NOW(a_inside_sign, i_clk, i_rst_n, o_out_valid && !o_outside, !o_height[HEIGHT_W-1], "on-grid height negative")

    // Reset empties the output
    `HTS_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind heightmap_triangle_sample_core htsamp_chk u_htsamp_chk (.*);

`default_nettype wire
